// ===== hdl/ilff_pkg.sv =====
// ----------------------------------------------------------------------------
// ilff_pkg
// Shared codes, command set and status flags of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ilff_pkg;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_ZERO = 2'd1;
    localparam logic [1:0] STAT_OOM  = 2'd2;

    localparam logic [31:0] LIST_START = 32'd8;

    typedef enum logic [5:0] {
        CMD_NOP,
        CMD_CLEAR,
        CMD_LOAD,
        CMD_RD_HDR,
        CMD_RD_BPM8,
        CMD_F_WHDR,
        CMD_F_WFTR,
        CMD_M_P,
        CMD_M_F,
        CMD_M_PA,
        CMD_M_N,
        CMD_M_NA,
        CMD_M_A1,
        CMD_M_A2,
        CMD_M_B1,
        CMD_M_B2,
        CMD_M_C1,
        CMD_M_C2,
        CMD_M_C3,
        CMD_M_RET,
        CMD_S_CHK,
        CMD_G_CHK,
        CMD_G_W2,
        CMD_G_W3,
        CMD_P_C,
        CMD_P_S2,
        CMD_P_S3,
        CMD_P_S4,
        CMD_P_N2,
        CMD_FIN_OK,
        CMD_FIN_FREE,
        CMD_FIN_ZERO,
        CMD_FIN_OOM
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic is_free;
        logic is_zero;
        logic s_end;
        logic s_fit;
        logic g_fail;
        logic split;
        logic pa;
        logic na;
    } flags_t;

endpackage

// ===== hdl/ilff_dpath.sv =====
// ----------------------------------------------------------------------------
// ilff_dpath
// Heap word store, block pointers, sizes and result registers.
// ----------------------------------------------------------------------------
module ilff_dpath
    import ilff_pkg::*;
#(
    parameter int HEAP_WORDS  = 65536,
    parameter int CHUNK_BYTES = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    input  logic        func,
    input  logic [18:0] request_size,
    input  logic [17:0] block_addr_in,
    output flags_t      flags,
    output logic [17:0] result_addr,
    output logic [1:0]  status
);

    localparam int AW = $clog2(HEAP_WORDS);
    localparam logic [31:0] LIMIT = 32'(HEAP_WORDS * 4);
    localparam logic [31:0] CHUNK_S = 32'(((CHUNK_BYTES / 4 + 1) / 2) * 8);
    localparam logic [31:0] CHUNK_LIM = 32'(CHUNK_BYTES);
    localparam logic CHUNK_FITS = (CHUNK_S <= LIMIT - 32'd16);
    localparam logic [31:0] INIT_BRK = CHUNK_FITS ? (32'd16 + CHUNK_S) : 32'd16;
    localparam logic [AW-1:0] IDX_FTR = AW'(2 + ((CHUNK_BYTES / 4 + 1) / 2) * 2);
    localparam logic [AW-1:0] IDX_EPI = AW'(3 + ((CHUNK_BYTES / 4 + 1) / 2) * 2);
    localparam logic [AW-1:0] IDX_LAST = AW'(HEAP_WORDS - 1);
    localparam logic [AW:0] CNT_MAX = (AW + 1)'(HEAP_WORDS);

    logic [31:0] mem [HEAP_WORDS];

    logic [31:0] rd_reg;
    logic [31:0] bp_reg, bp_next;
    logic [31:0] p_reg, p_next;
    logic [31:0] s_reg, s_next;
    logic [31:0] psz_reg, psz_next;
    logic [31:0] nsz_reg, nsz_next;
    logic [31:0] need_reg, need_next;
    logic [31:0] brk_reg, brk_next;
    logic        pa_reg, pa_next;
    logic        na_reg, na_next;
    logic        func_reg, func_next;
    logic        zero_reg, zero_next;
    logic [AW:0] cnt_reg, cnt_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [17:0] res_reg, res_next;
    logic [1:0]  st_reg, st_next;

    logic [31:0] mem_addr;
    logic [AW-1:0] mem_idx;
    logic        mem_we;
    logic [31:0] mem_wdata;
    logic [31:0] rsz;
    logic [31:0] sg;
    logic [31:0] csum;
    logic        s_end, s_fit, g_fail, split;

    function automatic logic [31:0] init_word(input logic [AW-1:0] idx);
        logic [31:0] v;
        v = 32'd0;
        if (idx == AW'(1) || idx == AW'(2))
        begin
            v = 32'd9;
        end
        else if (CHUNK_FITS)
        begin
            if (idx == AW'(3) || idx == IDX_FTR)
            begin
                v = CHUNK_S;
            end
            else if (idx == IDX_EPI)
            begin
                v = 32'd1;
            end
        end
        else if (idx == AW'(3))
        begin
            v = 32'd1;
        end
        return v;
    endfunction

    assign rsz = rd_reg & ~32'd7;
    assign sg = (need_reg > CHUNK_LIM) ? need_reg : CHUNK_S;
    assign csum = s_reg + psz_reg + nsz_reg;
    assign s_end = (rsz == 32'd0) || (cnt_reg == CNT_MAX);
    assign s_fit = !rd_reg[0] && (need_reg <= rsz);
    assign g_fail = (brk_reg > LIMIT) || (sg > LIMIT - brk_reg);
    assign split = (rsz - need_reg) >= 32'd16;

    always_comb
    begin
        flags.clr_last = (clr_reg == IDX_LAST);
        flags.is_free  = func_reg;
        flags.is_zero  = zero_reg;
        flags.s_end    = s_end;
        flags.s_fit    = s_fit;
        flags.g_fail   = g_fail;
        flags.split    = split;
        flags.pa       = pa_reg;
        flags.na       = na_reg;
    end

    always_comb
    begin
        bp_next   = bp_reg;
        p_next    = p_reg;
        s_next    = s_reg;
        psz_next  = psz_reg;
        nsz_next  = nsz_reg;
        need_next = need_reg;
        brk_next  = brk_reg;
        pa_next   = pa_reg;
        na_next   = na_reg;
        func_next = func_reg;
        zero_next = zero_reg;
        cnt_next  = cnt_reg;
        clr_next  = clr_reg;
        res_next  = res_reg;
        st_next   = st_reg;
        mem_addr  = bp_reg - 32'd4;
        mem_we    = 1'b0;
        mem_wdata = 32'd0;
        case (cmd)
            CMD_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_wdata = init_word(clr_reg);
                clr_next  = clr_reg + AW'(1);
            end
            CMD_LOAD:
            begin
                func_next = func;
                zero_next = (request_size == 19'd0);
                bp_next   = (func == FUNC_FREE) ? {14'd0, block_addr_in} : LIST_START;
                need_next = (request_size <= 19'd8) ? 32'd16
                          : (({13'd0, request_size} + 32'd15) & ~32'd7);
                cnt_next  = '0;
            end
            CMD_RD_HDR:
            begin
                mem_addr = bp_reg - 32'd4;
            end
            CMD_RD_BPM8:
            begin
                mem_addr = bp_reg - 32'd8;
            end
            CMD_F_WHDR:
            begin
                s_next    = rsz;
                mem_we    = 1'b1;
                mem_wdata = rsz;
            end
            CMD_F_WFTR, CMD_M_A2, CMD_G_W2:
            begin
                mem_addr  = bp_reg + s_reg - 32'd8;
                mem_we    = 1'b1;
                mem_wdata = s_reg;
            end
            CMD_M_P:
            begin
                p_next   = bp_reg - rsz;
                mem_addr = bp_reg - rsz - 32'd4;
            end
            CMD_M_F:
            begin
                psz_next = rsz;
                mem_addr = p_reg + rsz - 32'd8;
            end
            CMD_M_PA:
            begin
                pa_next = rd_reg[0];
            end
            CMD_M_N:
            begin
                s_next   = rsz;
                mem_addr = bp_reg + rsz - 32'd4;
            end
            CMD_M_NA:
            begin
                na_next  = rd_reg[0];
                nsz_next = rsz;
            end
            CMD_M_A1:
            begin
                s_next    = s_reg + nsz_reg;
                mem_we    = 1'b1;
                mem_wdata = s_reg + nsz_reg;
            end
            CMD_M_B1:
            begin
                s_next    = s_reg + psz_reg;
                mem_addr  = bp_reg + s_reg - 32'd8;
                mem_we    = 1'b1;
                mem_wdata = s_reg + psz_reg;
            end
            CMD_M_B2:
            begin
                mem_addr  = bp_reg - rsz - 32'd4;
                mem_we    = 1'b1;
                mem_wdata = s_reg;
            end
            CMD_M_C1:
            begin
                s_next    = csum;
                mem_addr  = p_reg - 32'd4;
                mem_we    = 1'b1;
                mem_wdata = csum;
            end
            CMD_M_C2:
            begin
                p_next   = bp_reg + rsz;
                mem_addr = bp_reg + rsz - 32'd4;
            end
            CMD_M_C3:
            begin
                mem_addr  = p_reg + rsz - 32'd8;
                mem_we    = 1'b1;
                mem_wdata = s_reg;
            end
            CMD_M_RET:
            begin
                bp_next = bp_reg - rsz;
            end
            CMD_S_CHK:
            begin
                mem_addr = bp_reg + rsz - 32'd4;
                if (!s_end && !s_fit)
                begin
                    bp_next  = bp_reg + rsz;
                    cnt_next = cnt_reg + (AW + 1)'(1);
                end
            end
            CMD_G_CHK:
            begin
                mem_addr = brk_reg - 32'd4;
                if (!g_fail)
                begin
                    bp_next   = brk_reg;
                    s_next    = sg;
                    brk_next  = brk_reg + sg;
                    mem_we    = 1'b1;
                    mem_wdata = sg;
                end
            end
            CMD_G_W3:
            begin
                mem_addr  = bp_reg + s_reg - 32'd4;
                mem_we    = 1'b1;
                mem_wdata = 32'd1;
            end
            CMD_P_C:
            begin
                s_next    = rsz;
                mem_we    = 1'b1;
                mem_wdata = split ? (need_reg | 32'd1) : (rsz | 32'd1);
            end
            CMD_P_S2:
            begin
                mem_addr  = bp_reg + need_reg - 32'd8;
                mem_we    = 1'b1;
                mem_wdata = need_reg | 32'd1;
            end
            CMD_P_S3:
            begin
                mem_addr  = bp_reg + need_reg - 32'd4;
                mem_we    = 1'b1;
                mem_wdata = s_reg - need_reg;
            end
            CMD_P_S4:
            begin
                mem_addr  = bp_reg + s_reg - 32'd8;
                mem_we    = 1'b1;
                mem_wdata = s_reg - need_reg;
            end
            CMD_P_N2:
            begin
                mem_addr  = bp_reg + s_reg - 32'd8;
                mem_we    = 1'b1;
                mem_wdata = s_reg | 32'd1;
            end
            CMD_FIN_OK:
            begin
                res_next = bp_reg[17:0];
                st_next  = STAT_OK;
            end
            CMD_FIN_FREE:
            begin
                res_next = 18'd0;
                st_next  = STAT_OK;
            end
            CMD_FIN_ZERO:
            begin
                res_next = 18'd0;
                st_next  = STAT_ZERO;
            end
            CMD_FIN_OOM:
            begin
                res_next = 18'd0;
                st_next  = STAT_OOM;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
        mem_idx = (cmd == CMD_CLEAR) ? clr_reg : mem_addr[AW+1:2];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_idx] <= mem_wdata;
        end
        rd_reg <= mem[mem_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brk_reg <= INIT_BRK;
            clr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            brk_reg <= brk_next;
            clr_reg <= clr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bp_reg   <= bp_next;
        p_reg    <= p_next;
        s_reg    <= s_next;
        psz_reg  <= psz_next;
        nsz_reg  <= nsz_next;
        need_reg <= need_next;
        pa_reg   <= pa_next;
        na_reg   <= na_next;
        func_reg <= func_next;
        zero_reg <= zero_next;
        res_reg  <= res_next;
        st_reg   <= st_next;
    end

    assign result_addr = res_reg;
    assign status      = st_reg;

endmodule

// ===== hdl/ilff_ctrl.sv =====
// ----------------------------------------------------------------------------
// ilff_ctrl
// Sequencer for the clearing pass, free, search, grow, merge and placement.
// ----------------------------------------------------------------------------
module ilff_ctrl
    import ilff_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_stall,
    output logic   out_valid,
    input  logic   out_stall,
    input  flags_t flags,
    output cmd_t   cmd
);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_DISP, S_F1, S_F2,
        S_M0, S_M1, S_M2, S_M3, S_M4, S_M5, S_MDEC,
        S_MA2, S_MB2, S_MB3, S_MC2, S_MC3, S_MC4, S_MR0, S_MR1, S_MEND,
        S_SRCH, S_G, S_G2, S_G3, S_P0, S_P1, S_PS2, S_PS3, S_PS4, S_PN2, S_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   grow_reg, grow_next;
    cmd_t   fin_reg, fin_next;
    logic   ov_reg, ov_next;
    logic   slot_free;

    assign slot_free = !ov_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        grow_next  = grow_reg;
        fin_next   = fin_reg;
        cmd        = CMD_NOP;
        ov_next    = ov_reg && out_stall;
        case (state_reg)
            S_CLEAR:
            begin
                cmd = CMD_CLEAR;
                if (flags.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd        = CMD_LOAD;
                    grow_next  = 1'b0;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                if (flags.is_free)
                begin
                    cmd        = CMD_RD_HDR;
                    state_next = S_F1;
                end
                else if (flags.is_zero)
                begin
                    fin_next   = CMD_FIN_ZERO;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd        = CMD_RD_HDR;
                    state_next = S_SRCH;
                end
            end
            S_F1:
            begin
                cmd        = CMD_F_WHDR;
                state_next = S_F2;
            end
            S_F2:
            begin
                cmd        = CMD_F_WFTR;
                state_next = S_M0;
            end
            S_M0:
            begin
                cmd        = CMD_RD_BPM8;
                state_next = S_M1;
            end
            S_M1:
            begin
                cmd        = CMD_M_P;
                state_next = S_M2;
            end
            S_M2:
            begin
                cmd        = CMD_M_F;
                state_next = S_M3;
            end
            S_M3:
            begin
                cmd        = CMD_M_PA;
                state_next = S_M4;
            end
            S_M4:
            begin
                cmd        = CMD_M_N;
                state_next = S_M5;
            end
            S_M5:
            begin
                cmd        = CMD_M_NA;
                state_next = S_MDEC;
            end
            S_MDEC:
            begin
                if (flags.pa && flags.na)
                begin
                    state_next = S_MEND;
                end
                else if (flags.pa)
                begin
                    cmd        = CMD_M_A1;
                    state_next = S_MA2;
                end
                else if (flags.na)
                begin
                    cmd        = CMD_M_B1;
                    state_next = S_MB2;
                end
                else
                begin
                    cmd        = CMD_M_C1;
                    state_next = S_MC2;
                end
            end
            S_MA2:
            begin
                cmd        = CMD_M_A2;
                state_next = S_MEND;
            end
            S_MB2:
            begin
                cmd        = CMD_RD_BPM8;
                state_next = S_MB3;
            end
            S_MB3:
            begin
                cmd        = CMD_M_B2;
                state_next = S_MR0;
            end
            S_MC2:
            begin
                cmd        = CMD_RD_HDR;
                state_next = S_MC3;
            end
            S_MC3:
            begin
                cmd        = CMD_M_C2;
                state_next = S_MC4;
            end
            S_MC4:
            begin
                cmd        = CMD_M_C3;
                state_next = S_MR0;
            end
            S_MR0:
            begin
                cmd        = CMD_RD_BPM8;
                state_next = S_MR1;
            end
            S_MR1:
            begin
                cmd        = CMD_M_RET;
                state_next = S_MEND;
            end
            S_MEND:
            begin
                if (grow_reg)
                begin
                    state_next = S_P0;
                end
                else
                begin
                    fin_next   = CMD_FIN_FREE;
                    state_next = S_FIN;
                end
            end
            S_SRCH:
            begin
                cmd = CMD_S_CHK;
                if (flags.s_end)
                begin
                    state_next = S_G;
                end
                else if (flags.s_fit)
                begin
                    state_next = S_P0;
                end
            end
            S_G:
            begin
                cmd = CMD_G_CHK;
                if (flags.g_fail)
                begin
                    fin_next   = CMD_FIN_OOM;
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_G2;
                end
            end
            S_G2:
            begin
                cmd        = CMD_G_W2;
                state_next = S_G3;
            end
            S_G3:
            begin
                cmd        = CMD_G_W3;
                grow_next  = 1'b1;
                state_next = S_M0;
            end
            S_P0:
            begin
                cmd        = CMD_RD_HDR;
                state_next = S_P1;
            end
            S_P1:
            begin
                cmd        = CMD_P_C;
                state_next = flags.split ? S_PS2 : S_PN2;
            end
            S_PS2:
            begin
                cmd        = CMD_P_S2;
                state_next = S_PS3;
            end
            S_PS3:
            begin
                cmd        = CMD_P_S3;
                state_next = S_PS4;
            end
            S_PS4:
            begin
                cmd        = CMD_P_S4;
                fin_next   = CMD_FIN_OK;
                state_next = S_FIN;
            end
            S_PN2:
            begin
                cmd        = CMD_P_N2;
                fin_next   = CMD_FIN_OK;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (slot_free)
                begin
                    cmd        = fin_reg;
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            grow_reg  <= 1'b0;
            fin_reg   <= CMD_FIN_FREE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            grow_reg  <= grow_next;
            fin_reg   <= fin_next;
            ov_reg    <= ov_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = ov_reg;

endmodule

// ===== hdl/implicit_list_first_fit_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// implicit_list_first_fit_allocator_unit
// First-fit heap allocator with boundary tags over an on-chip word store.
// ----------------------------------------------------------------------------
//   channel | handshake              | payload
//   in      | in_valid / in_stall    | func, request_size, block_addr_in
//   out     | out_valid / out_stall  | result_addr, status
//
// One request is handled at a time, one store access per cycle.
// An allocate runs longer for each block visited by the search,
// and longer again when the break has to grow.
// After reset a clearing pass writes every word of the initial heap.
// A finished result waits in the output register while the next request runs.
// ----------------------------------------------------------------------------
module implicit_list_first_fit_allocator_unit
    import ilff_pkg::*;
#(
    parameter int HEAP_WORDS  = 65536,
    parameter int CHUNK_BYTES = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [18:0] request_size,
    input  logic [17:0] block_addr_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [17:0] result_addr,
    output logic [1:0]  status
);

    cmd_t   cmd;
    flags_t flags;

    ilff_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .flags     (flags),
        .cmd       (cmd)
    );

    ilff_dpath #(
        .HEAP_WORDS  (HEAP_WORDS),
        .CHUNK_BYTES (CHUNK_BYTES)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .func          (func),
        .request_size  (request_size),
        .block_addr_in (block_addr_in),
        .flags         (flags),
        .result_addr   (result_addr),
        .status        (status)
    );

endmodule
